FILE: hdl/ffrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffrt_pkg
// Shared types and constants for the first-fit region table.
// ----------------------------------------------------------------------------
package ffrt_pkg;
  localparam int MAX_REGIONS = 16;
  localparam int ADDR_BITS   = 32;
  localparam int IDX_BITS    = $clog2(MAX_REGIONS);
  localparam int CNT_BITS    = $clog2(MAX_REGIONS + 1);
  localparam int FLAG_BITS   = 8;
  localparam int ENTRY_BITS  = 2 * ADDR_BITS + FLAG_BITS;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_INV  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start_addr;
    logic [ADDR_BITS-1:0] end_addr;
    logic [FLAG_BITS-1:0] flags;
  } entry_t;
endpackage

FILE: hdl/ffrt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffrt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ffrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/first_fit_region_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_table_core
// First-fit region allocator: table of sorted regions held in one RAM.
// ----------------------------------------------------------------------------
// channel  | dir | contents
// s_axis   | in  | tdata: op[1:0], range_start, range_end, alloc_size, flags
// m_axis   | out | tdata: status[1:0], alloc_addr
// cfg      | in  | cfg_we, cfg_index, cfg_data (0 base, 1 limit)
//
// An operation reads the table one entry at a time, each entry read from the
// registered RAM read port and then checked, the final gap included for allocate
// and add, and stops at the first hit. An insert or remove then shifts the
// entries above the hit, each moved entry read and then written back, after one
// decide and one shift setup step, and ends with one write-back (two for a split).
// Entries examined plus entries moved never exceed count + 1.
// Reset (rst, synchronous) clears the count and control; RAM is not cleared.
// One beat is held at a time; the result register is held until taken and a
// new beat is accepted only when it is empty, the cycle after the result beat.
// ----------------------------------------------------------------------------
module first_fit_region_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] op, [33:2] range_start, [65:34] range_end, [97:66] alloc_size,
  // [105:98] region_flags
  input  logic [111:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [33:2] alloc_addr
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int AW = ffrt_pkg::ADDR_BITS;
  localparam int IW = ffrt_pkg::IDX_BITS;
  localparam int CW = ffrt_pkg::CNT_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_CHK   = 7'b0000100,
    S_DEC   = 7'b0001000,
    S_MVRD  = 7'b0010000,
    S_MVWR  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state;
  logic [AW-1:0] space_base, space_limit;
  logic [CW-1:0] count;
  logic [1:0] op;
  logic [AW-1:0] rs, re, sz;
  logic [7:0] fl;
  logic [CW-1:0] idx;
  logic [AW-1:0] prev_end;
  logic [7:0] prev_flags;
  // start address of previous entry, kept for the allocate grow case
  logic [AW-1:0] prev_start_q;
  logic found;
  logic [CW-1:0] hit;
  ffrt_pkg::entry_t hit_e;
  logic [AW-1:0] gap_start;

  // planned edits
  logic          do_ins, do_del, do_mod, do_mod2;
  logic [CW-1:0] tgt;
  ffrt_pkg::entry_t new_e, mod_e;
  logic [CW-1:0] mod_idx;
  logic [CW-1:0] mv;
  logic mv_run;
  logic [1:0] res_status;
  logic [AW-1:0] res_addr;
  logic out_v;

  logic ram_we;
  logic [IW-1:0] ram_wa, ram_ra;
  ffrt_pkg::entry_t ram_wd, ram_rd;

  ffrt_ram #(.WIDTH(ffrt_pkg::ENTRY_BITS), .DEPTH(ffrt_pkg::MAX_REGIONS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  assign s_axis_tready = (state == S_IDLE) && !out_v;
  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {6'd0, res_addr, res_status};

  // gap fit for allocate at gap [gs, ge)
  logic [AW-1:0] gs, ge, top;
  logic [AW:0]   sum;
  logic          fits, last_gap;
  assign last_gap = (idx == count);
  assign gs  = (idx == '0) ? space_base : prev_end;
  assign ge  = last_gap ? space_limit : ram_rd.start_addr;
  assign sum = {1'b0, gs} + {1'b0, sz};
  assign top = sum[AW-1:0];
  assign fits = !sum[AW] && (top < ge) && (gs >= space_base) && (top < space_limit);

  logic add_ok, contains;
  assign add_ok = ((idx == '0) || (prev_end <= rs)) && (last_gap || ram_rd.start_addr >= re);
  assign contains = (rs >= ram_rd.start_addr) && (re <= ram_rd.end_addr);

  logic full;
  assign full = (count >= CW'(ffrt_pkg::MAX_REGIONS));

  always_comb begin
    ram_ra = idx[IW-1:0];
    ram_we = 1'b0; ram_wa = idx[IW-1:0]; ram_wd = mod_e;
    unique case (state)
      S_MVRD: ram_ra = do_ins ? IW'(mv - 1'b1) : IW'(mv + 1'b1);
      S_MVWR: begin ram_we = 1'b1; ram_wa = mv[IW-1:0]; ram_wd = ram_rd; end
      S_FIN: begin
        ram_we = do_ins || do_mod;
        ram_wa = do_ins ? tgt[IW-1:0] : mod_idx[IW-1:0];
        ram_wd = do_ins ? new_e : mod_e;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      unique case (cfg_index)
        ffrt_pkg::CFG_BASE:  space_base  <= cfg_data;
        ffrt_pkg::CFG_LIMIT: space_limit <= cfg_data;
      endcase
    end
    if (rst) begin
      state <= S_IDLE; count <= '0; out_v <= 1'b0; mv_run <= 1'b0;
      space_base <= '0; space_limit <= '1;
    end else begin
      if (out_v && m_axis_tready) out_v <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          op <= s_axis_tdata[1:0];
          rs <= s_axis_tdata[33:2];
          re <= s_axis_tdata[65:34];
          sz <= s_axis_tdata[97:66];
          fl <= s_axis_tdata[105:98];
          idx <= '0; found <= 1'b0;
          do_ins <= 1'b0; do_del <= 1'b0; do_mod <= 1'b0; do_mod2 <= 1'b0;
          res_status <= ffrt_pkg::ST_INV; res_addr <= '0;
          state <= S_RD;
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          // one entry (or the final gap) examined
          unique case (op)
            ffrt_pkg::OP_ALLOC: begin
              if (fits) begin
                found <= 1'b1; hit <= idx; gap_start <= gs;
                state <= S_DEC;
              end
            end
            ffrt_pkg::OP_FREE: begin
              if (!last_gap && contains) begin
                found <= 1'b1; hit <= idx; hit_e <= ram_rd; state <= S_DEC;
              end
            end
            ffrt_pkg::OP_ADD: begin
              if (add_ok) begin
                found <= 1'b1; hit <= idx; state <= S_DEC;
              end
            end
            default: ;
          endcase
          if (state == S_CHK && !((op == ffrt_pkg::OP_ALLOC && fits) ||
              (op == ffrt_pkg::OP_FREE && !last_gap && contains) ||
              (op == ffrt_pkg::OP_ADD && add_ok))) begin
            prev_end <= ram_rd.end_addr; prev_flags <= ram_rd.flags;
            prev_start_q <= ram_rd.start_addr;
            if (last_gap || (op == ffrt_pkg::OP_FREE && idx + 1'b1 == count) ||
                op == ffrt_pkg::OP_RSVD ||
                (op != ffrt_pkg::OP_ALLOC && (rs >= re || re >= space_limit))) begin
              state <= S_DEC;
            end else begin
              idx <= idx + 1'b1; state <= S_RD;
            end
          end
        end
        S_DEC: begin
          if (!found || op == ffrt_pkg::OP_RSVD ||
              (op != ffrt_pkg::OP_ALLOC && (rs >= re || re >= space_limit))) begin
            res_status <= ffrt_pkg::ST_INV;
          end else begin
            unique case (op)
              ffrt_pkg::OP_ALLOC: begin
                if (hit != '0 && prev_flags == fl) begin
                  do_mod <= 1'b1; mod_idx <= hit - 1'b1;
                  mod_e <= '{start_addr: prev_start_q, end_addr: gap_start + sz,
                             flags: prev_flags};
                  res_status <= ffrt_pkg::ST_OK; res_addr <= gap_start;
                end else if (full) begin
                  res_status <= ffrt_pkg::ST_FULL;
                end else begin
                  do_ins <= 1'b1; tgt <= hit;
                  new_e <= '{start_addr: gap_start, end_addr: gap_start + sz, flags: fl};
                  res_status <= ffrt_pkg::ST_OK; res_addr <= gap_start;
                end
              end
              ffrt_pkg::OP_FREE: begin
                mod_idx <= hit;
                priority if (rs == hit_e.start_addr && re == hit_e.end_addr) begin
                  do_del <= 1'b1; tgt <= hit;
                  res_status <= ffrt_pkg::ST_OK;
                end else if (rs == hit_e.start_addr) begin
                  do_mod <= 1'b1;
                  mod_e <= '{start_addr: re, end_addr: hit_e.end_addr, flags: hit_e.flags};
                  res_status <= ffrt_pkg::ST_OK;
                end else if (re == hit_e.end_addr) begin
                  do_mod <= 1'b1;
                  mod_e <= '{start_addr: hit_e.start_addr, end_addr: rs, flags: hit_e.flags};
                  res_status <= ffrt_pkg::ST_OK;
                end else if (full) begin
                  res_status <= ffrt_pkg::ST_FULL;
                end else begin
                  do_mod2 <= 1'b1; do_ins <= 1'b1; tgt <= hit + 1'b1;
                  new_e <= '{start_addr: re, end_addr: hit_e.end_addr, flags: hit_e.flags};
                  mod_e <= '{start_addr: hit_e.start_addr, end_addr: rs, flags: hit_e.flags};
                  res_status <= ffrt_pkg::ST_OK;
                end
              end
              default: begin
                if (full) res_status <= ffrt_pkg::ST_FULL;
                else begin
                  do_ins <= 1'b1; tgt <= hit;
                  new_e <= '{start_addr: rs, end_addr: re, flags: fl};
                  res_status <= ffrt_pkg::ST_OK;
                end
              end
            endcase
          end
          state <= S_MVRD;
        end
        S_MVRD: begin
          // set up shift; first entry into this state starts the move index
          if (!mv_run) begin
            mv_run <= 1'b1;
            mv <= do_ins ? count : tgt;
            if (do_ins ? (count == tgt) : (!do_del || tgt + 1'b1 >= count)) begin
              state <= S_FIN;
            end
          end else begin
            state <= S_MVWR;
          end
        end
        S_MVWR: begin
          mv <= do_ins ? mv - 1'b1 : mv + 1'b1;
          if (do_ins ? (mv - 1'b1 == tgt) : (mv + 2'd2 >= count)) state <= S_FIN;
          else state <= S_MVRD;
        end
        S_FIN: begin
          if (do_ins) count <= count + 1'b1;
          if (do_del) count <= count - 1'b1;
          if (do_mod2) begin
            do_mod2 <= 1'b0; do_ins <= 1'b0; do_mod <= 1'b1; do_del <= 1'b0;
            // second write: lower part of split at original slot
          end else begin
            out_v <= 1'b1; state <= S_IDLE;
          end
          mv_run <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == S_IDLE) else $error("ready outside idle");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ffrt_pkg::MAX_REGIONS)) else $error("count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_v && !m_axis_tready |=> out_v) else $error("result dropped");
endmodule
